// ----- hw/rtl/sfla_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfla_pkg: shared types and constants for the segregated free-list allocator
// Field widths, list geometry, action codes and transaction payload structs.
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam int HEAP_UNITS = 4096;
  localparam int BIN_COUNT  = 32;
  localparam int UNIT_BYTES = 32;

  localparam int ADDR_W  = 12;              // unit address width
  localparam int SIZE_W  = 13;              // block size in units, up to HEAP_UNITS
  localparam int BIN_W   = 5;               // bin index width
  localparam int BYTES_W = 18;
  localparam int UNIT_SH = 5;               // log2(UNIT_BYTES)
  localparam int UNITS_W = BYTES_W - UNIT_SH + 1;

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_REBUILD = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [BYTES_W-1:0] request_bytes;
    logic [ADDR_W-1:0]  unit_address;
  } in_item_t;

  typedef struct packed {
    logic              granted;
    logic [ADDR_W-1:0] block_start;
  } out_item_t;

  // header word: size, next valid, next address
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              has_next;
    logic [ADDR_W-1:0] next;
  } hdr_t;

endpackage

// ----- hw/rtl/segregated_free_list_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segregated_free_list_allocator_top: segregated-fit heap allocator
// Small bins by exact size plus one first-fit large list, headers in RAM.
// ----------------------------------------------------------------------------
//  channel | ports                      | payload
//  --------+----------------------------+-------------------------------
//  input   | in_valid / in_ready        | in_data  (action, bytes, addr)
//  result  | out_valid / out_ready      | out_data (granted, block_start)
//
// One transaction at a time. A refused or unknown request goes straight to
// the result; rebuild pushes one block; release reads the header, then pushes.
// Allocate probes the small bins at the size and its doublings, then walks the
// large list first-fit (one header RAM read per node, at most HEAP_UNITS nodes),
// then pops or unlinks, splits and pushes the rest.
// Sync active-low reset empties the bin heads and the large-list head; headers need no clearing.
// The result register holds while out_ready is low; in_ready stays low until
// the result is taken.
// ----------------------------------------------------------------------------
module segregated_free_list_allocator_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sfla_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sfla_pkg::out_item_t out_data
);

  localparam int AW = sfla_pkg::ADDR_W;
  localparam int SW = sfla_pkg::SIZE_W;
  localparam int UW = sfla_pkg::UNITS_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PROBE  = 4'd1;  // small bin probe
  localparam logic [3:0] S_BINRD  = 4'd2;  // wait for popped block header
  localparam logic [3:0] S_BINPOP = 4'd3;
  localparam logic [3:0] S_LRD    = 4'd4;  // large list read issued
  localparam logic [3:0] S_LCHK   = 4'd5;
  localparam logic [3:0] S_PRVRD  = 4'd6;  // reread prev for unlink
  localparam logic [3:0] S_UNLINK = 4'd7;
  localparam logic [3:0] S_SPLIT  = 4'd8;
  localparam logic [3:0] S_PUSH   = 4'd9;  // push block at push_addr
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0]    state_r;
  logic [1:0]    act_r;
  logic [UW-1:0] units_r;
  logic [5:0]    probe_r;       // grows past BIN_COUNT to end probing
  logic          bin_v_r [sfla_pkg::BIN_COUNT];
  logic [AW-1:0] bin_a_r [sfla_pkg::BIN_COUNT];
  logic          lg_v_r;
  logic [AW-1:0] lg_a_r;
  logic          have_prev_r;
  logic [AW-1:0] prev_r, cur_r, found_r;
  sfla_pkg::hdr_t cur_hdr_r;
  logic [AW:0]   steps_r;
  logic [AW-1:0] push_addr_r;
  logic [SW-1:0] push_size_r;
  logic          out_valid_r;
  sfla_pkg::out_item_t out_r;

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  sfla_pkg::hdr_t wdata, rdata;

  sfla_hdr_ram u_hdr (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // bin of the block being pushed
  logic          push_small;
  logic [sfla_pkg::BIN_W-1:0] push_bin;
  assign push_small = push_size_r < SW'(sfla_pkg::BIN_COUNT);
  assign push_bin   = push_size_r[sfla_pkg::BIN_W-1:0];

  // one bit of headroom so the round-up never wraps
  logic [UW-1:0] units_in;
  assign units_in = UW'((19'(in_data.request_bytes) + 19'(sfla_pkg::UNIT_BYTES - 1))
                        >> sfla_pkg::UNIT_SH);

  logic [SW:0] rest_addr;
  assign rest_addr = (SW+1)'(found_r) + (SW+1)'(units_r);

  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    we    = 1'b0;
    waddr = push_addr_r;
    wdata = cur_hdr_r;
    raddr = cur_r;
    case (state_r)
      S_PROBE:  raddr = bin_a_r[probe_r[sfla_pkg::BIN_W-1:0]];
      S_BINRD:  raddr = found_r;
      S_LRD:    raddr = cur_r;
      S_PRVRD:  raddr = prev_r;
      S_UNLINK: begin
        we    = have_prev_r;
        waddr = prev_r;
        wdata = '{size: rdata.size, has_next: cur_hdr_r.has_next, next: cur_hdr_r.next};
      end
      S_SPLIT: begin
        we    = cur_hdr_r.size > SW'(units_r);
        waddr = found_r;
        wdata = '{size: SW'(units_r), has_next: cur_hdr_r.has_next, next: cur_hdr_r.next};
      end
      S_PUSH: begin
        we    = 1'b1;
        waddr = push_addr_r;
        wdata = '{size: push_size_r,
                  has_next: push_small ? bin_v_r[push_bin] : lg_v_r,
                  next:     push_small ? bin_a_r[push_bin] : lg_a_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lg_v_r      <= 1'b0;
      for (int i = 0; i < sfla_pkg::BIN_COUNT; i++) bin_v_r[i] <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid && in_ready) begin
          act_r       <= in_data.action;
          units_r     <= units_in;
          probe_r     <= (units_in < UW'(sfla_pkg::BIN_COUNT)) ? 6'(units_in) : 6'd32;
          out_r       <= '{granted: in_data.action == sfla_pkg::ACT_REBUILD,
                           block_start: in_data.unit_address};
          push_addr_r <= in_data.unit_address;
          push_size_r <= SW'(sfla_pkg::HEAP_UNITS) - SW'(in_data.unit_address);
          cur_r       <= in_data.unit_address;
          case (in_data.action)
            sfla_pkg::ACT_ALLOC: state_r <= (units_in == '0) ? S_DONE : S_PROBE;
            sfla_pkg::ACT_RELEASE: state_r <= S_LRD;
            sfla_pkg::ACT_REBUILD: begin
              lg_v_r <= 1'b0;
              for (int i = 0; i < sfla_pkg::BIN_COUNT; i++) bin_v_r[i] <= 1'b0;
              state_r <= S_PUSH;
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_PROBE: begin
          if (probe_r >= 6'(sfla_pkg::BIN_COUNT)) begin
            cur_r       <= lg_a_r;
            have_prev_r <= 1'b0;
            steps_r     <= '0;
            state_r     <= lg_v_r ? S_LRD : S_DONE;
          end else if (bin_v_r[probe_r[sfla_pkg::BIN_W-1:0]]) begin
            found_r <= bin_a_r[probe_r[sfla_pkg::BIN_W-1:0]];
            state_r <= S_BINRD;
          end else begin
            probe_r <= probe_r << 1;
          end
        end
        S_BINRD: state_r <= S_BINPOP;
        S_BINPOP: begin
          bin_v_r[probe_r[sfla_pkg::BIN_W-1:0]] <= rdata.has_next;
          bin_a_r[probe_r[sfla_pkg::BIN_W-1:0]] <= rdata.next;
          cur_hdr_r <= rdata;
          state_r   <= S_SPLIT;
        end
        S_LRD: state_r <= S_LCHK;
        S_LCHK: begin
          cur_hdr_r <= rdata;
          if (act_r == sfla_pkg::ACT_RELEASE) begin
            // push by stored size
            push_size_r <= rdata.size;
            out_r.granted <= 1'b1;
            state_r <= S_PUSH;
          end else if ((UW+1)'(rdata.size) >= (UW+1)'(units_r)) begin
            found_r <= cur_r;
            if (have_prev_r) state_r <= S_PRVRD;
            else begin
              lg_v_r  <= rdata.has_next;
              lg_a_r  <= rdata.next;
              state_r <= S_SPLIT;
            end
          end else if (!rdata.has_next || steps_r == (AW+1)'(sfla_pkg::HEAP_UNITS - 1)) begin
            state_r <= S_DONE;
          end else begin
            have_prev_r <= 1'b1;
            prev_r      <= cur_r;
            cur_r       <= rdata.next;
            steps_r     <= steps_r + 1'b1;
            state_r     <= S_LRD;
          end
        end
        S_PRVRD: state_r <= S_UNLINK;
        S_UNLINK: state_r <= S_SPLIT;
        S_SPLIT: begin
          out_r <= '{granted: 1'b1, block_start: found_r};
          push_addr_r <= rest_addr[AW-1:0];
          push_size_r <= cur_hdr_r.size - SW'(units_r);
          if (cur_hdr_r.size > SW'(units_r) && !rest_addr[SW-1] && !rest_addr[SW])
            state_r <= S_PUSH;
          else
            state_r <= S_DONE;
        end
        S_PUSH: begin
          if (push_small) begin
            bin_v_r[push_bin] <= 1'b1;
            bin_a_r[push_bin] <= push_addr_r;
          end else begin
            lg_v_r <= 1'b1;
            lg_a_r <= push_addr_r;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/sfla_hdr_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfla_hdr_ram: block header store
// One write port, one registered read port, one header per heap unit.
// ----------------------------------------------------------------------------
module sfla_hdr_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [sfla_pkg::ADDR_W-1:0] waddr,
  input  sfla_pkg::hdr_t             wdata,
  input  logic [sfla_pkg::ADDR_W-1:0] raddr,
  output sfla_pkg::hdr_t             rdata
);

  sfla_pkg::hdr_t mem [sfla_pkg::HEAP_UNITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: segregated free-list allocator
// Directed and random allocate/release/rebuild traffic with random gaps on
// both channels. Each result transaction is checked against an in-bench copy
// of the bins, the large list and the block headers.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [1:0] ACT_UNKNOWN = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int AW = sfla_pkg::ADDR_W;
  localparam int BW = sfla_pkg::BIN_W;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  sfla_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  sfla_pkg::out_item_t out_data;

  segregated_free_list_allocator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow heap: bin heads, large-list head and the header array.
  // hdr_written tracks which headers hold real data, since the RTL header
  // RAM is not cleared at reset; releases only ever target written headers.
  // --------------------------------------------------------------------------
  logic           bin_valid [sfla_pkg::BIN_COUNT];
  logic [AW-1:0]  bin_addr  [sfla_pkg::BIN_COUNT];
  logic           large_valid;
  logic [AW-1:0]  large_addr;
  sfla_pkg::hdr_t headers   [sfla_pkg::HEAP_UNITS];
  bit             hdr_written [sfla_pkg::HEAP_UNITS];

  logic [AW-1:0] live_blocks[$];     // granted and not yet released
  logic [AW-1:0] ever_granted[$];    // any block ever handed out

  sfla_pkg::out_item_t pending_results[$];
  int        mismatches = 0;
  bit        no_idle = 1'b0;

  function automatic void clear_bins();
    for (int i = 0; i < sfla_pkg::BIN_COUNT; i++) begin
      bin_valid[i] = 1'b0;
      bin_addr[i]  = '0;
    end
    large_valid = 1'b0;
    large_addr  = '0;
  endfunction

  // push a block onto its bin (or the large list) by its stored size
  function automatic void push_free(logic [AW-1:0] b);
    logic [sfla_pkg::SIZE_W-1:0] sz;
    sz = headers[b].size;
    if (sz < sfla_pkg::BIN_COUNT) begin
      headers[b].has_next = bin_valid[sz[BW-1:0]];
      headers[b].next     = bin_addr[sz[BW-1:0]];
      bin_valid[sz[BW-1:0]] = 1'b1;
      bin_addr[sz[BW-1:0]]  = b;
    end else begin
      headers[b].has_next = large_valid;
      headers[b].next     = large_addr;
      large_valid = 1'b1;
      large_addr  = b;
    end
  endfunction

  // bins at units, 2x, 4x ... then first fit on the large list
  function automatic bit take_free(logic [13:0] units, output logic [AW-1:0] found);
    logic [15:0]   probe;
    bit            have_prev;
    logic [AW-1:0] prev;
    logic          cur_valid;
    logic [AW-1:0] cur;
    int            steps;
    probe = 16'(units);
    found = '0;
    while (probe < sfla_pkg::BIN_COUNT) begin
      if (bin_valid[probe[BW-1:0]]) begin
        found = bin_addr[probe[BW-1:0]];
        bin_valid[probe[BW-1:0]] = headers[found].has_next;
        bin_addr[probe[BW-1:0]]  = headers[found].next;
        return 1'b1;
      end
      probe = probe << 1;
    end
    have_prev = 1'b0;
    prev = '0;
    cur_valid = large_valid;
    cur = large_addr;
    steps = 0;
    while (cur_valid && steps < sfla_pkg::HEAP_UNITS) begin
      if (headers[cur].size >= units) begin
        if (have_prev) begin
          headers[prev].has_next = headers[cur].has_next;
          headers[prev].next     = headers[cur].next;
        end else begin
          large_valid = headers[cur].has_next;
          large_addr  = headers[cur].next;
        end
        found = cur;
        return 1'b1;
      end
      have_prev = 1'b1;
      prev = cur;
      cur_valid = headers[cur].has_next;
      cur = headers[cur].next;
      steps++;
    end
    return 1'b0;
  endfunction

  function automatic sfla_pkg::out_item_t allocator_apply(sfla_pkg::in_item_t it);
    sfla_pkg::out_item_t res;
    logic [13:0]         units;
    logic [AW-1:0]       b;
    logic [13:0]         sz;
    int                  rest;
    res.granted = 1'b0;
    res.block_start = it.unit_address;
    case (it.action)
      sfla_pkg::ACT_ALLOC: begin
        units = 14'((19'(it.request_bytes) + sfla_pkg::UNIT_BYTES - 1)
                    / sfla_pkg::UNIT_BYTES);
        if (units != 0 && take_free(units, b)) begin
          sz = 14'(headers[b].size);
          if (sz > units) begin
            rest = int'(b) + int'(units);
            if (rest < sfla_pkg::HEAP_UNITS) begin
              headers[AW'(rest)].size = sfla_pkg::SIZE_W'(sz - units);
              hdr_written[AW'(rest)] = 1'b1;
              push_free(AW'(rest));
            end
            headers[b].size = sfla_pkg::SIZE_W'(units);
          end
          res.granted = 1'b1;
          res.block_start = b;
          live_blocks.push_back(b);
          ever_granted.push_back(b);
        end
      end
      sfla_pkg::ACT_RELEASE: begin
        push_free(it.unit_address);
        res.granted = 1'b1;
      end
      sfla_pkg::ACT_REBUILD: begin
        clear_bins();
        live_blocks.delete();
        headers[it.unit_address].size =
          sfla_pkg::SIZE_W'(sfla_pkg::HEAP_UNITS - int'(it.unit_address));
        hdr_written[it.unit_address] = 1'b1;
        push_free(it.unit_address);
        res.granted = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Input side: one transaction per call, with a random lead-in gap.
  // in_valid is only lowered at the start of a gap, so back-to-back items
  // keep it high without a same-step drop.
  // --------------------------------------------------------------------------
  task automatic send_item(sfla_pkg::in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(allocator_apply(it));
  endtask

  function automatic sfla_pkg::in_item_t make_item(logic [1:0] act,
                                                   logic [sfla_pkg::BYTES_W-1:0] bytes,
                                                   logic [AW-1:0] addr);
    sfla_pkg::in_item_t it;
    it.action = act;
    it.request_bytes = bytes;
    it.unit_address = addr;
    return it;
  endfunction

  task automatic send_alloc(logic [sfla_pkg::BYTES_W-1:0] bytes);
    send_item(make_item(sfla_pkg::ACT_ALLOC, bytes, AW'($urandom)));
  endtask

  task automatic send_release(logic [AW-1:0] addr);
    send_item(make_item(sfla_pkg::ACT_RELEASE, sfla_pkg::BYTES_W'($urandom), addr));
  endtask

  task automatic send_rebuild(logic [AW-1:0] addr);
    send_item(make_item(sfla_pkg::ACT_REBUILD, sfla_pkg::BYTES_W'($urandom), addr));
  endtask

  // --------------------------------------------------------------------------
  // Result side: ready stalls drawn per transaction, checker on every edge.
  // --------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (out_valid && out_ready) begin
      stall_left = no_idle ? 0 : $urandom_range(0, 11);
      out_ready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= (stall_left == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sfla_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction granted=%0b block_start=%0d",
                 $time, out_data.granted, out_data.block_start);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.granted !== want.granted) begin
          $display("%0t: granted expected %0b actual %0b",
                   $time, want.granted, out_data.granted);
          mismatches++;
        end
        if (out_data.block_start !== want.block_start) begin
          $display("%0t: block_start expected %0d actual %0d",
                   $time, want.block_start, out_data.block_start);
          mismatches++;
        end
      end
    end
  end

  // hard stop if the block hangs
  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty heap after reset: nothing fits, unknown action is ignored.
  task automatic test_empty_heap();
    send_alloc(18'd64);
    send_alloc(18'd1);
    send_item(make_item(ACT_UNKNOWN, 18'h3FFFF, 12'hFFF));
  endtask

  // Size extremes, bin probing, split into bins and into the large list.
  task automatic test_size_edges();
    send_rebuild(12'd0);
    send_alloc(18'd0);                 // zero request refused
    send_alloc(18'd1);                 // one unit, remainder to large list
    send_alloc(18'd32);
    send_alloc(18'd33);                // rounds up to two units
    send_alloc(18'd992);               // 31 units, largest small size
    send_alloc(18'd1024);              // 32 units, first large size
    send_alloc(18'h3FFFF);             // far beyond the heap
    send_alloc(18'd131072);            // whole heap, does not fit any more
    while (live_blocks.size() > 0) send_release(live_blocks.pop_front());
    send_alloc(18'd1);                 // exact bin hit
    send_alloc(18'd64);                // two units, exact hit in bin 2
    send_rebuild(12'd4095);            // single-unit heap tail
    send_alloc(18'd1);
    send_alloc(18'd1);                 // nothing left
    send_rebuild(12'd4064);            // 32-unit block on the large list
    send_alloc(18'd1024);
  endtask

  // Releasing one large block twice leaves a self-loop on the large list;
  // a miss must walk the capped number of steps and report no fit.
  task automatic test_double_release();
    logic [AW-1:0] blk;
    send_rebuild(12'd0);
    send_alloc(18'd2048);
    blk = live_blocks.pop_front();
    send_release(blk);
    send_release(blk);
    send_alloc(18'd131072);
    send_alloc(18'd96);                // still served from the looped block
    send_rebuild(12'd0);
  endtask

  // Random mix, mostly allocate/release on a rebuilt heap.
  task automatic test_random_traffic(int count);
    int                            r;
    int                            idx;
    logic [AW-1:0]                 blk;
    logic [sfla_pkg::BYTES_W-1:0]  bytes;
    for (int i = 0; i < count; i++) begin
      no_idle = ((i / 100) % 3 == 1);
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_rebuild((r < 2) ? AW'($urandom) : AW'($urandom_range(0, 63)));
      end else if (r < 6) begin
        send_item(make_item(ACT_UNKNOWN, sfla_pkg::BYTES_W'($urandom), AW'($urandom)));
      end else if (r < 8 && ever_granted.size() > 0) begin
        // stale release, only small blocks so no large-list loop forms
        blk = ever_granted[$urandom_range(0, ever_granted.size() - 1)];
        if (headers[blk].size < sfla_pkg::BIN_COUNT && hdr_written[blk]) send_release(blk);
        else send_alloc(sfla_pkg::BYTES_W'($urandom_range(1, 512)));
      end else if (r < 42 && live_blocks.size() > 0) begin
        idx = $urandom_range(0, live_blocks.size() - 1);
        blk = live_blocks[idx];
        live_blocks.delete(idx);
        send_release(blk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) bytes = '0;
        else if (r < 10) bytes = sfla_pkg::BYTES_W'($urandom);
        else if (r < 25) bytes = sfla_pkg::BYTES_W'($urandom_range(1024, 8192));
        else bytes = sfla_pkg::BYTES_W'($urandom_range(1, 1024));
        send_alloc(bytes);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < sfla_pkg::HEAP_UNITS; i++) begin
      headers[i] = '0;
      hdr_written[i] = 1'b0;
    end
    clear_bins();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_heap();
    test_size_edges();
    test_double_release();
    test_random_traffic(900);

    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
